### rtl/nal_start_code_stripper_macros.svh
// assertion macros shared by the checker of the start code stripper
`ifndef NAL_START_CODE_STRIPPER_MACROS_SVH
`define NAL_START_CODE_STRIPPER_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define NSCS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define NSCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/nscs_pkg.sv
// shared types and constants of the start code stripper
package nscs_pkg;

   localparam int DEF_MAX_UNITS   = 32;
   localparam int DEF_PARAM_BYTES = 64;
   localparam int QUEUE_DEPTH     = 4;

   // widest store index over the parameter range
   localparam int IDX_W  = 8;
   // store banks: staging, sps, pps and one spare
   localparam int BANK_W = 2;

   localparam logic [1:0] BANK_STAGE_INIT = 2'd0;
   localparam logic [1:0] BANK_SPS_INIT   = 2'd1;
   localparam logic [1:0] BANK_PPS_INIT   = 2'd2;

   localparam logic [4:0] TYPE_SPS = 5'd7;
   localparam logic [4:0] TYPE_PPS = 5'd8;

   localparam logic [7:0] CODE_ZERO = 8'h00;
   localparam logic [7:0] CODE_ONE  = 8'h01;
   localparam logic [2:0] LONG_CODE_LEN  = 3'd4;
   localparam logic [2:0] SHORT_CODE_LEN = 3'd3;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 40;

   // result tdata bit positions
   localparam int RSP_BYTE_LSB  = 0;
   localparam int RSP_TYPE_LSB  = 8;
   localparam int RSP_NUM_LSB   = 13;
   localparam int RSP_READY_BIT = 18;
   localparam int RSP_SPS_LSB   = 19;
   localparam int RSP_PPS_LSB   = 26;
   localparam int RSP_LAST_BIT  = 33;

   // one queued command: a store read or a group of up to four results
   typedef struct packed {
      logic             is_read;
      logic             hit;
      logic [1:0]       bank;
      logic [IDX_W-1:0] base;
      logic             wr_en;
      logic [2:0]       count;
      logic             marker;
      logic             unit_end;
      logic [3:0][7:0]  bytes;
      logic [4:0]       unit_type;
      logic [4:0]       unit_number;
      logic             params_ready;
      logic [6:0]       sps_length;
      logic [6:0]       pps_length;
   } cmd_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       unit_end;
      logic [4:0] unit_type;
      logic [4:0] unit_number;
      logic       params_ready;
      logic [6:0] sps_length;
      logic [6:0] pps_length;
      logic       last;
   } rsp_type;

endpackage

### rtl/nscs_ram.sv
// generic simple dual port ram with registered read
module nscs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/nscs_fifo.sv
// short command queue between front and back
module nscs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   assign dout  = mem_ff[rd_ptr_ff];
   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

endmodule

### rtl/nscs_front.sv
// front: start code judgment, unit bookkeeping and parameter set status
module nscs_front import nscs_pkg::*; #(
   parameter int MAX_UNITS   = DEF_MAX_UNITS,
   parameter int PARAM_BYTES = DEF_PARAM_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       req_type,
   input  logic [7:0] data_byte,
   input  logic       unit_first,
   input  logic       unit_final,
   input  logic       frame_first,
   input  logic       read_which,
   input  logic [5:0] read_index,
   output logic       push,
   output cmd_type    cmd
);

   localparam int UC_W  = $clog2(MAX_UNITS + 1);
   localparam int PC_W  = $clog2(PARAM_BYTES + 2);
   localparam int CNT_W = $clog2(PARAM_BYTES + 1);
   localparam int RW    = (CNT_W > 6) ? CNT_W : 6;

   logic [3:0][7:0]  look_ff, look_in;
   logic [1:0]       held_ff, held_in;
   logic             decided_ff, decided_in;
   logic             dropped_ff, dropped_in;
   logic [UC_W-1:0]  counter_ff, counter_in;
   logic [PC_W-1:0]  pcount_ff, pcount_in;
   logic [4:0]       ctype_ff, ctype_in;
   logic             ready_ff, ready_in;
   logic [CNT_W-1:0] sps_cnt_ff, sps_cnt_in;
   logic [CNT_W-1:0] pps_cnt_ff, pps_cnt_in;
   logic [1:0]       stg_bank_ff, stg_bank_in;
   logic [1:0]       sps_bank_ff, sps_bank_in;
   logic [1:0]       pps_bank_ff, pps_bank_in;

   logic             go;
   logic [2:0]       held_n;
   logic [2:0]       skip;
   logic [2:0]       nres;
   logic [3:0][7:0]  view;
   logic [3:0][7:0]  shifted;
   logic [UC_W-1:0]  num;
   logic [RW-1:0]    idx_x;
   logic [RW-1:0]    cnt_x;

   always_comb begin
      look_in     = look_ff;
      held_in     = held_ff;
      decided_in  = decided_ff;
      dropped_in  = dropped_ff;
      counter_in  = counter_ff;
      pcount_in   = pcount_ff;
      ctype_in    = ctype_ff;
      ready_in    = ready_ff;
      sps_cnt_in  = sps_cnt_ff;
      pps_cnt_in  = pps_cnt_ff;
      stg_bank_in = stg_bank_ff;
      sps_bank_in = sps_bank_ff;
      pps_bank_in = pps_bank_ff;
      push        = 1'b0;
      cmd         = '0;
      go          = 1'b0;
      held_n      = '0;
      skip        = '0;
      nres        = '0;
      view        = look_ff;
      shifted     = look_ff;
      num         = '0;
      idx_x       = RW'(read_index);
      cnt_x       = read_which ? RW'(pps_cnt_ff) : RW'(sps_cnt_ff);

      if (accept && req_type) begin
         // store read: status stays as it is
         push             = 1'b1;
         cmd.is_read      = 1'b1;
         cmd.hit          = ready_ff && (idx_x < cnt_x) && (idx_x < RW'(PARAM_BYTES));
         cmd.bank         = read_which ? pps_bank_ff : sps_bank_ff;
         cmd.base         = IDX_W'(read_index);
         cmd.count        = 3'd1;
         cmd.params_ready = ready_ff;
         cmd.sps_length   = 7'(sps_cnt_ff);
         cmd.pps_length   = 7'(pps_cnt_ff);
      end else if (accept) begin
         if (unit_first) begin
            if (frame_first) begin
               counter_in = '0;
            end
            held_in    = '0;
            decided_in = 1'b0;
            ctype_in   = '0;
            pcount_in  = '0;
            if (counter_in >= UC_W'(MAX_UNITS)) begin
               dropped_in = 1'b1;
            end else begin
               dropped_in = 1'b0;
               counter_in = counter_in + 1'b1;
               go         = 1'b1;
            end
         end else begin
            go = !(dropped_ff || (held_ff == '0 && !decided_ff));
         end

         if (go) begin
            num       = counter_in - 1'b1;
            cmd.bank  = stg_bank_ff;
            cmd.count = 3'd1;
            if (decided_in) begin
               // one payload byte after the prefix
               if (pcount_in == '0) begin
                  ctype_in = data_byte[4:0];
               end
               cmd.wr_en    = !ready_ff && (pcount_in < PC_W'(PARAM_BYTES));
               cmd.base     = IDX_W'(pcount_in);
               cmd.bytes[0] = data_byte;
               cmd.unit_end = unit_final;
               if (pcount_in < PC_W'(PARAM_BYTES + 1)) begin
                  pcount_in = pcount_in + 1'b1;
               end
               push = 1'b1;
            end else begin
               look_in[held_in] = data_byte;
               view[held_in]    = data_byte;
               held_n           = {1'b0, held_in} + 3'd1;
               if (held_n == LONG_CODE_LEN || unit_final) begin
                  if (held_n == LONG_CODE_LEN && view[0] == CODE_ZERO &&
                      view[1] == CODE_ZERO && view[2] == CODE_ZERO &&
                      view[3] == CODE_ONE) begin
                     skip = LONG_CODE_LEN;
                  end else if (held_n >= SHORT_CODE_LEN && view[0] == CODE_ZERO &&
                               view[1] == CODE_ZERO && view[2] == CODE_ONE) begin
                     skip = SHORT_CODE_LEN;
                  end
                  shifted = view;
                  if (skip == SHORT_CODE_LEN) begin
                     shifted[0] = view[3];
                  end
                  nres       = held_n - skip;
                  decided_in = 1'b1;
                  held_in    = '0;
                  if (nres != '0) begin
                     ctype_in     = shifted[0][4:0];
                     cmd.wr_en    = !ready_ff;
                     cmd.count    = nres;
                     cmd.bytes    = shifted;
                     cmd.unit_end = unit_final;
                     pcount_in    = PC_W'(nres);
                     push         = 1'b1;
                  end else if (unit_final) begin
                     // empty payload marker
                     cmd.marker   = 1'b1;
                     cmd.unit_end = 1'b1;
                     push         = 1'b1;
                  end
               end else begin
                  held_in = held_n[1:0];
               end
            end

            if (unit_final) begin
               if (!ready_ff && pcount_in != '0 && pcount_in <= PC_W'(PARAM_BYTES)) begin
                  // capture by handing the staging bank over
                  if (ctype_in == TYPE_SPS) begin
                     sps_cnt_in  = CNT_W'(pcount_in);
                     stg_bank_in = sps_bank_ff;
                     sps_bank_in = stg_bank_ff;
                  end else if (ctype_in == TYPE_PPS) begin
                     pps_cnt_in  = CNT_W'(pcount_in);
                     stg_bank_in = pps_bank_ff;
                     pps_bank_in = stg_bank_ff;
                  end
                  ready_in = (sps_cnt_in != '0) && (pps_cnt_in != '0);
               end
               held_in    = '0;
               decided_in = 1'b0;
               dropped_in = 1'b1;
            end

            cmd.unit_type    = cmd.marker ? 5'd0 : ctype_in;
            cmd.unit_number  = 5'(num);
            cmd.params_ready = ready_in;
            cmd.sps_length   = 7'(sps_cnt_in);
            cmd.pps_length   = 7'(pps_cnt_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= '0;
         decided_ff  <= 1'b0;
         dropped_ff  <= 1'b0;
         counter_ff  <= '0;
         pcount_ff   <= '0;
         ctype_ff    <= '0;
         ready_ff    <= 1'b0;
         sps_cnt_ff  <= '0;
         pps_cnt_ff  <= '0;
         stg_bank_ff <= BANK_STAGE_INIT;
         sps_bank_ff <= BANK_SPS_INIT;
         pps_bank_ff <= BANK_PPS_INIT;
      end else begin
         held_ff     <= held_in;
         decided_ff  <= decided_in;
         dropped_ff  <= dropped_in;
         counter_ff  <= counter_in;
         pcount_ff   <= pcount_in;
         ctype_ff    <= ctype_in;
         ready_ff    <= ready_in;
         sps_cnt_ff  <= sps_cnt_in;
         pps_cnt_ff  <= pps_cnt_in;
         stg_bank_ff <= stg_bank_in;
         sps_bank_ff <= sps_bank_in;
         pps_bank_ff <= pps_bank_in;
      end
   end

   always_ff @(posedge clock) begin
      look_ff <= look_in;
   end

endmodule

### rtl/nscs_back.sv
// back: steps through queued commands, owns the parameter set ram
module nscs_back import nscs_pkg::*; #(
   parameter int PARAM_BYTES = DEF_PARAM_BYTES
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type head,
   input  logic    head_valid,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   localparam int IW    = $clog2(PARAM_BYTES);
   localparam int AW    = BANK_W + IW;
   localparam int DEPTH = (2 ** BANK_W) * (2 ** IW);

   logic [1:0]    sub_ff, sub_in;
   logic          valid_ff, valid_in;
   logic          from_ram_ff, from_ram_in;
   rsp_type       res_ff, res_in;
   logic          issue;
   logic          final_res;
   logic          ram_we;
   logic          ram_re;
   logic [AW-1:0] ram_waddr;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_q;

   assign issue     = head_valid && (!valid_ff || rsp_ready);
   assign final_res = (sub_ff == 2'(head.count - 3'd1));
   assign pop       = issue && final_res;

   assign ram_we    = issue && !head.is_read && head.wr_en && !head.marker;
   assign ram_waddr = {head.bank, head.base[IW-1:0] + IW'(sub_ff)};
   assign ram_re    = issue && head.is_read && head.hit;
   assign ram_raddr = {head.bank, head.base[IW-1:0]};

   always_comb begin
      sub_in      = sub_ff;
      valid_in    = valid_ff;
      res_in      = res_ff;
      from_ram_in = from_ram_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (issue) begin
         sub_in                = final_res ? 2'd0 : sub_ff + 2'd1;
         valid_in              = 1'b1;
         from_ram_in           = head.is_read && head.hit;
         res_in.out_byte       = head.bytes[sub_ff];
         res_in.byte_valid     = head.is_read ? head.hit : !head.marker;
         res_in.unit_end       = head.unit_end && final_res;
         res_in.unit_type      = head.unit_type;
         res_in.unit_number    = head.unit_number;
         res_in.params_ready   = head.params_ready;
         res_in.sps_length     = head.sps_length;
         res_in.pps_length     = head.pps_length;
         res_in.last           = final_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      from_ram_ff <= from_ram_in;
   end

   nscs_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (head.bytes[sub_ff]),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   always_comb begin
      rsp = res_ff;
      if (from_ram_ff) begin
         rsp.out_byte = ram_q;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

### rtl/nal_start_code_stripper.sv
// top level of the annex b start code stripper
// channels
//   req_ stream: one nal unit byte or one parameter set read per request
//   rsp_ stream: zero to four results per stream byte, one per read;
//   the last bit of rsp_tdata marks the final result of a request
//   the first bytes of a unit are held until the start code is judged
//   (fourth byte or final byte), then the payload part is released
// latency and throughput
//   one request per clock is taken while the queue has room; with nothing
//   ahead, a request passes the queue and output register before rsp_tvalid
//   rises; while rsp_tready is high, results leave at one per clock; a judged
//   prefix releases up to four results from a request, walked one per clock by
//   the back end through its single output register and single ram write port
// reset
//   synchronous reset empties the queue and output register and clears the
//   unit index, the capture counts and the ready flag; no clearing pass,
//   store bytes are only read back after they were written
// stall
//   a stalled receiver holds the output register, the queue fills and
//   req_tready drops once four commands wait
module nal_start_code_stripper import nscs_pkg::*; #(
   parameter int MAX_UNITS   = DEF_MAX_UNITS,
   parameter int PARAM_BYTES = DEF_PARAM_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // data_byte[7:0], unit_first[8], frame_first[9], read_which[10],
   // read_index[16:11], zero fill up to bit 23
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type: 0 stream byte, 1 parameter set read
   input  logic                   req_tuser,
   // unit_final
   input  logic                   req_tlast,
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_byte[7:0], unit_type[12:8], unit_number[17:13], params_ready[18],
   // sps_length[25:19], pps_length[32:26], last[33], zero fill up to bit 39
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // byte_valid
   output logic                   rsp_tuser,
   // unit_end
   output logic                   rsp_tlast
);

   localparam int CMD_W = $bits(cmd_type);

   logic             accept;
   logic             push;
   cmd_type          cmd;
   logic             queue_full;
   logic             queue_empty;
   logic             pop;
   logic [CMD_W-1:0] queue_dout;
   cmd_type          head;
   rsp_type          rsp;

   // a request is taken whenever the queue has a free slot
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // front end: prefix judgment and all unit and capture bookkeeping
   nscs_front #(
      .MAX_UNITS   (MAX_UNITS),
      .PARAM_BYTES (PARAM_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_type    (req_tuser),
      .data_byte   (req_tdata[7:0]),
      .unit_first  (req_tdata[8]),
      .unit_final  (req_tlast),
      .frame_first (req_tdata[9]),
      .read_which  (req_tdata[10]),
      .read_index  (req_tdata[16:11]),
      .push        (push),
      .cmd         (cmd)
   );

   // commands wait here so front and back stall independently
   nscs_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (cmd),
      .full  (queue_full),
      .pop   (pop),
      .dout  (queue_dout),
      .empty (queue_empty)
   );

   assign head = queue_dout;

   // back end: result sequencing, staging writes and store reads
   nscs_back #(
      .PARAM_BYTES (PARAM_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!queue_empty),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   // pack the result fields onto the stream
   assign rsp_tdata = {6'd0, rsp.last, rsp.pps_length, rsp.sps_length,
                       rsp.params_ready, rsp.unit_number, rsp.unit_type,
                       rsp.out_byte};
   assign rsp_tuser = rsp.byte_valid;
   assign rsp_tlast = rsp.unit_end;

endmodule

### rtl/nscs_checker.sv
// port level checker for the start code stripper, bound to the top level
`include "nal_start_code_stripper_macros.svh"

module nscs_checker import nscs_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser,
   input logic                   rsp_tlast
);

   logic rsp_take;
   logic seen_ready_ff, seen_ready_in;

   assign rsp_take = rsp_tvalid && rsp_tready;

   // sticky once a delivered result showed both sets captured
   assign seen_ready_in = seen_ready_ff || (rsp_take && rsp_tdata[RSP_READY_BIT]);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ready_ff <= 1'b0;
      end else begin
         seen_ready_ff <= seen_ready_in;
      end
   end

   `NSCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")
   `NSCS_ASSERT_IMPLY(a_empty_byte_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[RSP_TYPE_LSB-1:RSP_BYTE_LSB] == 8'd0, "result without byte carries data")
   `NSCS_ASSERT_IMPLY(a_unit_end_last, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[RSP_LAST_BIT], "unit end not last result of request")
   `NSCS_ASSERT_IMPLY(a_ready_sticky, clock, reset, rsp_take && seen_ready_ff, rsp_tdata[RSP_READY_BIT], "parameter sets ready flag dropped")

endmodule

bind nal_start_code_stripper nscs_checker u_checker (.*);

### sim/tb_nal_start_code_stripper.sv
// self-checking testbench for the annex b start code stripper
`timescale 1ns / 100ps

module tb_nal_start_code_stripper import nscs_pkg::*; ();

   // request kinds on req_tuser
   localparam logic REQ_STREAM = 1'b0;
   localparam logic REQ_READ   = 1'b1;
   // parameter set selector for reads
   localparam logic SET_SPS = 1'b0;
   localparam logic SET_PPS = 1'b1;
   // start code shapes put in front of a generated unit
   localparam int PFX_NONE  = 0;
   localparam int PFX_SHORT = 1;
   localparam int PFX_LONG  = 2;
   localparam int PFX_NOISE = 3;

   localparam int MAX_UNITS    = DEF_MAX_UNITS;
   localparam int PARAM_BYTES  = DEF_PARAM_BYTES;
   localparam int NUM_DIRECTED = 25;
   localparam int ITEM_TOTAL   = NUM_DIRECTED + 330;
   localparam int HOLD_CYCLES  = 60;
   localparam int TAIL_CYCLES  = 10;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int MAX_SHOWN    = 40;

   // one request of the directed table; want is used only when typed is set
   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic       first;
      logic       unit_last;
      logic       frame;
      logic       which;
      logic [5:0] idx;
      logic       typed;
      rsp_type    want;
   } stim_row_type;

   // fields: out_byte, byte_valid, unit_end, unit_type, unit_number,
   // params_ready, sps_length, pps_length, last
   localparam rsp_type NO_RESULT  = '{8'h00, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0, 7'd0, 7'd0, 1'b0};
   localparam rsp_type EMPTY_READ = '{8'h00, 1'b0, 1'b0, 5'd0, 5'd0, 1'b0, 7'd0, 7'd0, 1'b1};
   // empty unit right after reset: unit 0, nothing captured yet
   localparam rsp_type MARKER_U0  = '{8'h00, 1'b0, 1'b1, 5'd0, 5'd0, 1'b0, 7'd0, 7'd0, 1'b1};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // data_byte[7:0], unit_first[8], frame_first[9], read_which[10],
   // read_index[16:11], zero fill up to bit 23
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // req_type
   logic                   req_tuser = 1'b0;
   // unit_final
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // out_byte[7:0], unit_type[12:8], unit_number[17:13], params_ready[18],
   // sps_length[25:19], pps_length[32:26], last[33], zero fill up to bit 39
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // byte_valid
   logic                   rsp_tuser;
   // unit_end
   logic                   rsp_tlast;

   nal_start_code_stripper dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // predictor state: lookahead, unit bookkeeping and parameter set stores
   // ------------------------------------------------------------------
   logic [7:0] la_bytes [4];
   int         la_count       = 0;
   logic       prefix_known   = 1'b0;
   logic       unit_skipped   = 1'b0;
   int         units_in_frame = 0;
   int         payload_len    = 0;
   logic [4:0] cur_type       = '0;
   logic [7:0] stage_mem [PARAM_BYTES];
   logic [7:0] sps_mem [PARAM_BYTES];
   logic [7:0] pps_mem [PARAM_BYTES];
   int         sps_len        = 0;
   int         pps_len        = 0;
   logic       sets_ready     = 1'b0;

   rsp_type    step_results [$];
   rsp_type    strip_expected [$];

   int         sent_count  = 0;
   int         error_count = 0;
   int         cycle_count = 0;
   logic       steady      = 1'b0;
   logic       hold_req    = 1'b0;
   rsp_type    seen_rsp;
   rsp_type    due_rsp;

   function automatic void push_result(logic [7:0] b, logic v, logic e, logic [4:0] t,
                                       logic [4:0] n);
      rsp_type r;
      r = NO_RESULT;
      r.out_byte    = b;
      r.byte_valid  = v;
      r.unit_end    = e;
      r.unit_type   = t;
      r.unit_number = n;
      step_results.push_back(r);
   endfunction

   // one payload byte leaves; the first one fixes the unit type
   function automatic void give_byte(logic [7:0] b, logic e);
      if (payload_len == 0)
         cur_type = b[4:0];
      if (!sets_ready && payload_len < PARAM_BYTES)
         stage_mem[payload_len] = b;
      if (payload_len < PARAM_BYTES + 1)
         payload_len++;
      push_result(b, 1'b1, e, cur_type, 5'(units_in_frame - 1));
   endfunction

   // final byte seen: commit a captured sps or pps that fits the store
   function automatic void end_unit();
      if (!sets_ready && payload_len >= 1 && payload_len <= PARAM_BYTES) begin
         if (cur_type == TYPE_SPS) begin
            for (int i = 0; i < payload_len; i++)
               sps_mem[i] = stage_mem[i];
            sps_len = payload_len;
         end else if (cur_type == TYPE_PPS) begin
            for (int i = 0; i < payload_len; i++)
               pps_mem[i] = stage_mem[i];
            pps_len = payload_len;
         end
         if (sps_len > 0 && pps_len > 0)
            sets_ready = 1'b1;
      end
      la_count     = 0;
      prefix_known = 1'b0;
      unit_skipped = 1'b1;
   endfunction

   function automatic void strip_byte(logic [7:0] b, logic first, logic fin, logic frame);
      int n;
      int skip;
      if (first) begin
         if (frame)
            units_in_frame = 0;
         la_count     = 0;
         prefix_known = 1'b0;
         cur_type     = '0;
         payload_len  = 0;
         // frame already full: the whole unit is dropped
         if (units_in_frame >= MAX_UNITS) begin
            unit_skipped = 1'b1;
            return;
         end
         unit_skipped = 1'b0;
         units_in_frame++;
      end else if (unit_skipped || (la_count == 0 && !prefix_known)) begin
         // stray byte outside any unit
         return;
      end
      if (prefix_known) begin
         give_byte(b, fin);
      end else begin
         la_bytes[la_count] = b;
         la_count++;
         // judge the held bytes on the fourth byte or at the end of the unit
         if (la_count >= 4 || fin) begin
            n    = la_count;
            skip = 0;
            if (n == 4 && la_bytes[0] == CODE_ZERO && la_bytes[1] == CODE_ZERO &&
                la_bytes[2] == CODE_ZERO && la_bytes[3] == CODE_ONE)
               skip = int'(LONG_CODE_LEN);
            else if (n >= 3 && la_bytes[0] == CODE_ZERO && la_bytes[1] == CODE_ZERO &&
                     la_bytes[2] == CODE_ONE)
               skip = int'(SHORT_CODE_LEN);
            prefix_known = 1'b1;
            la_count     = 0;
            for (int i = skip; i < n; i++)
               give_byte(la_bytes[i], fin && (i == n - 1));
            // nothing left after the start code: a lone end marker
            if (fin && skip == n)
               push_result(8'h00, 1'b0, 1'b1, 5'd0, 5'(units_in_frame - 1));
         end
      end
      if (fin)
         end_unit();
   endfunction

   function automatic void read_back(logic which, logic [5:0] idx);
      int         cnt;
      logic [7:0] b;
      logic       v;
      cnt = (which == SET_PPS) ? pps_len : sps_len;
      b   = 8'h00;
      v   = 1'b0;
      if (sets_ready && idx < cnt) begin
         b = (which == SET_PPS) ? pps_mem[idx] : sps_mem[idx];
         v = 1'b1;
      end
      push_result(b, v, 1'b0, 5'd0, 5'd0);
   endfunction

   // works out every result of one accepted request
   function automatic void predict_strip(stim_row_type r);
      rsp_type o;
      step_results.delete();
      if (r.kind == REQ_READ)
         read_back(r.which, r.idx);
      else
         strip_byte(r.data, r.first, r.unit_last, r.frame);
      if (r.typed) begin
         strip_expected.push_back(r.want);
      end else begin
         foreach (step_results[k]) begin
            o              = step_results[k];
            o.params_ready = sets_ready;
            o.sps_length   = 7'(sps_len);
            o.pps_length   = 7'(pps_len);
            o.last         = (k == step_results.size() - 1);
            strip_expected.push_back(o);
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // request generation
   // ------------------------------------------------------------------

   // idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 65)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   function automatic int pick_prefix();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return PFX_SHORT;
      if (r < 75)
         return PFX_LONG;
      if (r < 90)
         return PFX_NONE;
      return PFX_NOISE;
   endfunction

   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return 0;
      if (r < 85)
         return $urandom_range(1, 6);
      return $urandom_range(7, 20);
   endfunction

   function automatic logic [4:0] pick_type_no_pps();
      logic [4:0] t;
      do
         t = 5'($urandom_range(0, 31));
      while (t == TYPE_PPS);
      return t;
   endfunction

   // stream byte; the read fields carry junk that the block must ignore
   function automatic stim_row_type byte_row(logic [7:0] d, logic f, logic l, logic fr);
      stim_row_type r;
      r           = '0;
      r.kind      = REQ_STREAM;
      r.data      = d;
      r.first     = f;
      r.unit_last = l;
      r.frame     = fr;
      r.which     = 1'($urandom_range(0, 1));
      r.idx       = 6'($urandom_range(0, 63));
      return r;
   endfunction

   // store read, mostly inside the captured length
   function automatic stim_row_type read_row();
      stim_row_type r;
      int           cnt;
      r           = '0;
      r.kind      = REQ_READ;
      r.data      = 8'($urandom_range(0, 255));
      r.first     = 1'($urandom_range(0, 1));
      r.unit_last = 1'($urandom_range(0, 1));
      r.frame     = 1'($urandom_range(0, 1));
      r.which     = 1'($urandom_range(0, 1));
      cnt         = (r.which == SET_PPS) ? pps_len : sps_len;
      if (cnt == 0 || $urandom_range(0, 3) == 0)
         r.idx = 6'($urandom_range(0, 63));
      else
         r.idx = 6'($urandom_range(0, cnt - 1));
      return r;
   endfunction

   // drives one request at the falling edge and waits for the handshake
   task automatic send_req(input stim_row_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = r.kind;
      req_tlast  = r.unit_last;
      req_tdata  = {7'd0, r.idx, r.which, r.frame, r.first, r.data};
      do
         @(posedge clock);
      while (!req_tready);
      predict_strip(r);
      sent_count++;
   endtask

   // one unit: optional start code, header byte, random body; a cut unit
   // stops early without its final byte and is abandoned by the next one
   task automatic send_unit(logic new_frame, int pfx, logic [4:0] typ, int len, logic cut);
      logic [7:0] ub [$];
      logic [7:0] hdr;
      int         keep;
      case (pfx)
         PFX_SHORT: ub = '{CODE_ZERO, CODE_ZERO, CODE_ONE};
         PFX_LONG:  ub = '{CODE_ZERO, CODE_ZERO, CODE_ZERO, CODE_ONE};
         PFX_NOISE: begin
            case ($urandom_range(0, 3))
               0: ub = '{CODE_ZERO, CODE_ZERO, 8'h02};
               1: ub = '{CODE_ZERO, CODE_ONE};
               2: ub = '{CODE_ZERO, CODE_ZERO, CODE_ZERO, CODE_ZERO, CODE_ONE};
               default: ub = '{CODE_ZERO};
            endcase
         end
         default: ;
      endcase
      hdr = {3'($urandom_range(0, 7)), typ};
      if (len == 0 && ub.size() == 0)
         len = 1;
      if (len > 0)
         ub.push_back(hdr);
      for (int k = 1; k < len; k++)
         ub.push_back(8'($urandom_range(0, 255)));
      if (cut) begin
         keep = $urandom_range(1, ub.size());
         while (ub.size() > keep)
            void'(ub.pop_back());
      end
      for (int k = 0; k < ub.size(); k++) begin
         // reads slipped in between stream bytes leave the unit untouched
         if (!steady && $urandom_range(0, 99) < 6)
            send_req(read_row());
         send_req(byte_row(ub[k], k == 0, !cut && (k == ub.size() - 1),
                           (k == 0) ? new_frame : ($urandom_range(0, 19) == 0)));
      end
   endtask

   // sender goes idle until every pending result is back
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (strip_expected.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // directed table
   // ------------------------------------------------------------------
   // kind, data, first, last, frame, which, idx, typed, expected
   stim_row_type script [NUM_DIRECTED] = '{
      // reads right after reset: nothing captured yet
      '{REQ_READ,   8'h00, 1'b0, 1'b0, 1'b0, SET_SPS, 6'd0,  1'b1, EMPTY_READ},
      '{REQ_READ,   8'hFF, 1'b1, 1'b1, 1'b1, SET_PPS, 6'd63, 1'b1, EMPTY_READ},
      // stray byte outside any unit
      '{REQ_STREAM, 8'hFF, 1'b0, 1'b0, 1'b0, SET_SPS, 6'd0,  1'b0, NO_RESULT},
      // short start code alone: empty payload marker
      '{REQ_STREAM, 8'h00, 1'b1, 1'b0, 1'b1, SET_SPS, 6'd0,  1'b0, NO_RESULT},
      '{REQ_STREAM, 8'h00, 1'b0, 1'b0, 1'b0, SET_SPS, 6'd0,  1'b0, NO_RESULT},
      '{REQ_STREAM, 8'h01, 1'b0, 1'b1, 1'b0, SET_SPS, 6'd0,  1'b1, MARKER_U0},
      // unit restarted before its end
      '{REQ_STREAM, 8'h00, 1'b1, 1'b0, 1'b0, SET_SPS, 6'd0,  1'b0, NO_RESULT},
      '{REQ_STREAM, 8'h41, 1'b1, 1'b1, 1'b0, SET_SPS, 6'd0,  1'b0, NO_RESULT},
      // no start code, frame flag on a middle byte is ignored
      '{REQ_STREAM, 8'h09, 1'b1, 1'b0, 1'b0, SET_SPS, 6'd0,  1'b0, NO_RESULT},
      '{REQ_STREAM, 8'h12, 1'b0, 1'b0, 1'b1, SET_SPS, 6'd0,  1'b0, NO_RESULT},
      '{REQ_STREAM, 8'h34, 1'b0, 1'b0, 1'b0, SET_SPS, 6'd0,  1'b0, NO_RESULT},
      '{REQ_STREAM, 8'h56, 1'b0, 1'b1, 1'b0, SET_SPS, 6'd0,  1'b0, NO_RESULT},
      // long start code then a two byte sps
      '{REQ_STREAM, 8'h00, 1'b1, 1'b0, 1'b0, SET_SPS, 6'd0,  1'b0, NO_RESULT},
      '{REQ_STREAM, 8'h00, 1'b0, 1'b0, 1'b0, SET_SPS, 6'd0,  1'b0, NO_RESULT},
      '{REQ_STREAM, 8'h00, 1'b0, 1'b0, 1'b0, SET_SPS, 6'd0,  1'b0, NO_RESULT},
      '{REQ_STREAM, 8'h01, 1'b0, 1'b0, 1'b0, SET_SPS, 6'd0,  1'b0, NO_RESULT},
      '{REQ_STREAM, 8'h67, 1'b0, 1'b0, 1'b0, SET_SPS, 6'd0,  1'b0, NO_RESULT},
      '{REQ_STREAM, 8'hAA, 1'b0, 1'b1, 1'b0, SET_SPS, 6'd0,  1'b0, NO_RESULT},
      // two zero bytes ending the unit are payload, not a start code
      '{REQ_STREAM, 8'h00, 1'b1, 1'b0, 1'b0, SET_SPS, 6'd0,  1'b0, NO_RESULT},
      '{REQ_STREAM, 8'h00, 1'b0, 1'b1, 1'b0, SET_SPS, 6'd0,  1'b0, NO_RESULT},
      // read while only the sps is held
      '{REQ_READ,   8'h00, 1'b0, 1'b0, 1'b0, SET_SPS, 6'd1,  1'b0, NO_RESULT},
      // long start code alone: marker
      '{REQ_STREAM, 8'h00, 1'b1, 1'b0, 1'b0, SET_SPS, 6'd0,  1'b0, NO_RESULT},
      '{REQ_STREAM, 8'h00, 1'b0, 1'b0, 1'b0, SET_SPS, 6'd0,  1'b0, NO_RESULT},
      '{REQ_STREAM, 8'h00, 1'b0, 1'b0, 1'b0, SET_SPS, 6'd0,  1'b0, NO_RESULT},
      '{REQ_STREAM, 8'h01, 1'b0, 1'b1, 1'b0, SET_SPS, 6'd0,  1'b0, NO_RESULT}
   };

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      error_count++;
      if (error_count <= MAX_SHOWN)
         $display("cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
   endtask

   task automatic cmp_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_mismatch(name, got, want);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_rsp.out_byte     = rsp_tdata[RSP_BYTE_LSB +: 8];
         seen_rsp.byte_valid   = rsp_tuser;
         seen_rsp.unit_end     = rsp_tlast;
         seen_rsp.unit_type    = rsp_tdata[RSP_TYPE_LSB +: 5];
         seen_rsp.unit_number  = rsp_tdata[RSP_NUM_LSB +: 5];
         seen_rsp.params_ready = rsp_tdata[RSP_READY_BIT];
         seen_rsp.sps_length   = rsp_tdata[RSP_SPS_LSB +: 7];
         seen_rsp.pps_length   = rsp_tdata[RSP_PPS_LSB +: 7];
         seen_rsp.last         = rsp_tdata[RSP_LAST_BIT];
         if (strip_expected.size() == 0) begin
            report_mismatch("result with nothing pending, out_byte", seen_rsp.out_byte, 8'h00);
         end else begin
            due_rsp = strip_expected.pop_front();
            cmp_field("out_byte",     seen_rsp.out_byte,         due_rsp.out_byte);
            cmp_field("byte_valid",   8'(seen_rsp.byte_valid),   8'(due_rsp.byte_valid));
            cmp_field("unit_end",     8'(seen_rsp.unit_end),     8'(due_rsp.unit_end));
            cmp_field("unit_type",    8'(seen_rsp.unit_type),    8'(due_rsp.unit_type));
            cmp_field("unit_number",  8'(seen_rsp.unit_number),  8'(due_rsp.unit_number));
            cmp_field("params_ready", 8'(seen_rsp.params_ready), 8'(due_rsp.params_ready));
            cmp_field("sps_length",   8'(seen_rsp.sps_length),   8'(due_rsp.sps_length));
            cmp_field("pps_length",   8'(seen_rsp.pps_length),   8'(due_rsp.pps_length));
            cmp_field("last",         8'(seen_rsp.last),         8'(due_rsp.last));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_nal_start_code_stripper NOT OK");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            stall = pick_gap();
            if (stall == 0) begin
               rsp_tready = 1'b1;
            end else begin
               rsp_tready = 1'b0;
               repeat (stall - 1) @(negedge clock);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   initial begin
      int r;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[i])
         send_req(script[i]);

      // capture phase: the stores only fill before both sets are held
      repeat (3)
         send_unit(1'b0, pick_prefix(), pick_type_no_pps(), $urandom_range(0, 6), 1'b0);
      send_unit(1'b0, PFX_SHORT, TYPE_SPS, PARAM_BYTES, 1'b0);
      repeat (3)
         send_req(read_row());
      // one byte too long: the earlier sps stays
      send_unit(1'b0, PFX_LONG, TYPE_SPS, PARAM_BYTES + 1, 1'b0);
      // abandoned sps is not committed
      send_unit(1'b0, PFX_SHORT, TYPE_SPS, 8, 1'b1);
      send_unit(1'b0, PFX_LONG, 5'd5, 3, 1'b0);
      send_unit(1'b0, PFX_SHORT, TYPE_PPS, $urandom_range(1, 12), 1'b0);
      repeat (10)
         send_req(read_row());

      // sender pause until every pending result is back
      wait_drained();

      // one frame with more units than it may hold, no idling
      steady = 1'b1;
      for (int u = 0; u < MAX_UNITS + 4; u++)
         send_unit(u == 0, ($urandom_range(0, 3) == 0) ? PFX_SHORT : PFX_NONE,
                   5'($urandom_range(0, 31)), $urandom_range(0, 1), 1'b0);

      // receiver holds off while the sender keeps pushing
      hold_req = 1'b1;
      repeat (10)
         send_unit(1'b0, PFX_SHORT, 5'($urandom_range(0, 31)), $urandom_range(1, 4), 1'b0);
      steady = 1'b0;

      // general mix: mostly well-formed units, some reads and stray bytes
      while (sent_count < ITEM_TOTAL) begin
         r = $urandom_range(0, 99);
         if (r < 80)
            send_unit($urandom_range(0, 6) == 0, pick_prefix(), 5'($urandom_range(0, 31)),
                      pick_len(), $urandom_range(0, 11) == 0);
         else if (r < 93)
            send_req(read_row());
         else
            send_req(byte_row(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1))));
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (strip_expected.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_nal_start_code_stripper OK");
      else
         $display("tb_nal_start_code_stripper NOT OK");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/nscs_pkg.sv
rtl/nscs_ram.sv
rtl/nscs_fifo.sv
rtl/nscs_front.sv
rtl/nscs_back.sv
rtl/nal_start_code_stripper.sv
rtl/nscs_checker.sv
sim/tb_nal_start_code_stripper.sv
